// ===== src/psdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 device byte transmitter - shared definitions
// Command codes, frame timing constants, the result record and the line
// encoder that maps a frame phase and a byte onto the open-drain drives.
// ----------------------------------------------------------------------------
package psdt_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RAW   = 2'd1,
    CMD_MAKE  = 2'd2,
    CMD_BREAK = 2'd3
  } psdt_cmd_t;

  localparam logic [5:0]  LAST_PHASE    = 6'd36;
  localparam logic [5:0]  LAST_BIT_PHASE = 6'd33;
  localparam logic [7:0]  BREAK_PREFIX  = 8'hF0;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;

  typedef enum logic {
    REG_SENDING_ENABLED = 1'b0,
    REG_PHASE_TICKS     = 1'b1
  } psdt_reg_t;

  typedef struct packed {
    logic       clock_low;
    logic       data_low;
  } psdt_lines_t;

  typedef struct packed {
    logic       clock_low;
    logic       data_low;
    logic       frame_busy;
    logic       push_accepted;
    logic [4:0] queued_bytes;
  } psdt_result_t;

  // Frame phase 1..33 covers 11 bit slots of setup, clock low, clock high.
  function automatic psdt_lines_t frame_lines(input logic [5:0] phase,
                                              input logic [7:0] data);
    logic [3:0]  slot;
    logic [5:0]  sub;
    logic        level;
    psdt_lines_t lines;
    slot = 4'd0;
    for (int i = 1; i <= 10; i++) begin
      if (phase >= 6'(3 * i + 1)) slot = 4'(i);
    end
    sub = phase - 6'd1 - 6'(3 * slot);
    if (slot == 4'd0) begin
      level = 1'b0;
    end else if (slot <= 4'd8) begin
      level = data[3'(slot - 4'd1)];
    end else if (slot == 4'd9) begin
      level = ~^data;
    end else begin
      level = 1'b1;
    end
    lines.clock_low = (sub == 6'd1);
    lines.data_low  = ~level;
    return lines;
  endfunction

endpackage

// ===== src/psdt_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 device byte transmitter - send ring
// Single-port-write ring memory with registered read of the oldest entry.
// The second byte of a break push lands in the next cycle from a pending slot.
// ----------------------------------------------------------------------------
module psdt_ring #(
  parameter int RING_DEPTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  psdt_pkg::psdt_cmd_t    cmd,
  input  logic [7:0]             byte_value,
  input  logic                   sending_enabled,
  input  logic                   pop,
  output logic                   accepted,
  output logic                   nonempty,
  output logic [4:0]             queued_next,
  output logic [7:0]             head_byte,
  output logic                   pend_busy
);
  import psdt_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);

  logic [7:0]    mem [RING_DEPTH];
  logic [PW-1:0] wr_ptr, wr_ptr_next;
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic [PW-1:0] w1, w2;
  logic          pend_valid;
  logic [PW-1:0] pend_addr;
  logic [7:0]    pend_data;
  logic          set_pend;
  logic          we;
  logic [PW-1:0] waddr;
  logic [7:0]    wdata;
  logic [PW:0]   diff;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign w1 = inc(wr_ptr);
  assign w2 = inc(w1);
  assign nonempty = (wr_ptr != rd_ptr);

  always_comb begin
    wr_ptr_next = wr_ptr;
    accepted    = 1'b0;
    set_pend    = 1'b0;
    we          = 1'b0;
    waddr       = wr_ptr;
    wdata       = byte_value;
    if (push) begin
      unique case (cmd)
        CMD_RAW, CMD_MAKE: begin
          if ((cmd == CMD_RAW || sending_enabled) && w1 != rd_ptr) begin
            we          = 1'b1;
            wr_ptr_next = w1;
            accepted    = 1'b1;
          end
        end
        CMD_BREAK: begin
          if (sending_enabled && w1 != rd_ptr) begin
            we          = 1'b1;
            wdata       = BREAK_PREFIX;
            wr_ptr_next = w1;
            if (w2 != rd_ptr) begin
              set_pend    = 1'b1;
              wr_ptr_next = w2;
              accepted    = 1'b1;
            end
          end
        end
        CMD_TICK: begin
        end
        default: begin
        end
      endcase
    end
    // Input is held off while a pending byte drains.
    if (pend_valid) begin
      we    = 1'b1;
      waddr = pend_addr;
      wdata = pend_data;
    end
  end

  assign rd_ptr_next = pop ? inc(rd_ptr) : rd_ptr;

  always_comb begin
    diff = {1'b0, wr_ptr_next} - {1'b0, rd_ptr_next};
    if (wr_ptr_next < rd_ptr_next) diff = diff + (PW + 1)'(RING_DEPTH);
  end
  assign queued_next = 5'(diff[PW-1:0]);
  assign pend_busy   = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      pend_valid <= 1'b0;
    end else begin
      wr_ptr     <= wr_ptr_next;
      rd_ptr     <= rd_ptr_next;
      pend_valid <= set_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (set_pend) begin
      pend_addr <= w1;
      pend_data <= byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    head_byte <= mem[rd_ptr];
  end

endmodule

// ===== src/psdt_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 device byte transmitter - frame sequencer
// Counts ticks per phase, walks the 37 frame phases and encodes the lines.
// ----------------------------------------------------------------------------
module psdt_framer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick,
  input  logic                  nonempty,
  input  logic [15:0]           phase_ticks,
  input  logic [7:0]            head_byte,
  output logic                  pop,
  output logic                  busy_next,
  output psdt_pkg::psdt_lines_t lines
);
  import psdt_pkg::*;

  logic        active, active_next;
  logic [5:0]  phase, phase_next;
  logic [15:0] count, count_next;
  logic [16:0] count_plus;
  logic [15:0] limit;

  assign limit      = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
  assign count_plus = {1'b0, count} + 17'd1;

  always_comb begin
    active_next = active;
    phase_next  = phase;
    count_next  = count;
    pop         = 1'b0;
    if (tick) begin
      if (!active) begin
        if (nonempty) begin
          active_next = 1'b1;
          phase_next  = '0;
          count_next  = '0;
        end
      end else if (count_plus >= {1'b0, limit}) begin
        count_next = '0;
        if (phase >= LAST_PHASE) begin
          active_next = 1'b0;
          phase_next  = '0;
          pop         = 1'b1;
        end else begin
          phase_next = phase + 6'd1;
        end
      end else begin
        count_next = count_plus[15:0];
      end
    end
  end

  always_comb begin
    lines = '0;
    if (active_next && phase_next >= 6'd1 && phase_next <= LAST_BIT_PHASE) begin
      lines = frame_lines(phase_next, head_byte);
    end
  end

  assign busy_next = active_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      phase  <= '0;
      count  <= '0;
    end else begin
      active <= active_next;
      phase  <= phase_next;
      count  <= count_next;
    end
  end

endmodule

// ===== src/psdt_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 device byte transmitter - result stage
// Output register with one skid entry behind it.
// ----------------------------------------------------------------------------
module psdt_out (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  psdt_pkg::psdt_result_t result,
  input  logic                   out_stall,
  output logic                   out_valid,
  output psdt_pkg::psdt_result_t out_data,
  output logic                   skid_full
);
  import psdt_pkg::*;

  psdt_result_t skid;
  logic         skid_valid;
  logic         room;

  assign room      = !out_valid || !out_stall;
  assign skid_full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (room) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (load) begin
      if (room) out_valid <= 1'b1;
      else skid_valid <= 1'b1;
    end else if (room) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (room) out_data <= skid;
    end else if (load) begin
      if (room) out_data <= result;
      else skid <= result;
    end
  end

endmodule

// ===== src/ps2_device_byte_transmitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 device byte transmitter
// Queues bytes in a send ring and frames the oldest one on the PS/2 lines.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): command and byte_value. A tick
//   advances the line timing; raw, make and break commands push bytes.
//   Every accepted transaction yields exactly one result transaction on the
//   output channel (out_valid / out_stall) carrying the line drives, the
//   frame busy flag, the push outcome and the ring fill after the item.
//   The result is registered at the accepting edge.
//   Throughput is one transaction per cycle. The exception is a break push
//   that stores both bytes: the ring memory has one write port, so the
//   second byte is written the next cycle and input is stalled for it.
//   When the receiver stalls, the output register holds its result and one
//   more result goes to a skid entry; input stalls while that entry is full.
//   Reset clears pointers, frame timing and output state; sending_enabled
//   returns to 1 and phase_ticks to 100. Ring contents are not cleared.
//   Configuration (config_write / config_index / config_data) is to be
//   written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module ps2_device_byte_transmitter #(
  parameter int RING_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        clock_low,
  output logic        data_low,
  output logic        frame_busy,
  output logic        push_accepted,
  output logic [4:0]  queued_bytes,
  input  logic        config_write,
  input  logic        config_index,
  input  logic [15:0] config_data
);
  import psdt_pkg::*;

  logic         sending_enabled;
  logic [15:0]  phase_ticks;
  logic         accept;
  logic         tick;
  logic         push;
  psdt_cmd_t    cmd;
  logic         pop;
  logic         nonempty;
  logic         accepted;
  logic [4:0]   queued_next;
  logic [7:0]   head_byte;
  logic         pend_busy;
  logic         busy_next;
  logic         skid_full;
  psdt_lines_t  lines;
  psdt_result_t result;
  psdt_result_t out_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sending_enabled <= 1'b1;
      phase_ticks     <= PHASE_TICKS_RESET;
    end else if (config_write) begin
      unique case (psdt_reg_t'(config_index))
        REG_SENDING_ENABLED: sending_enabled <= config_data[0];
        REG_PHASE_TICKS:     phase_ticks     <= config_data;
        default: begin
        end
      endcase
    end
  end

  // Hold input while a break byte drains into the ring or the skid is full.
  assign in_stall = pend_busy || skid_full;
  assign accept   = in_valid && !in_stall;
  assign cmd      = psdt_cmd_t'(command);
  assign tick     = accept && (cmd == CMD_TICK);
  assign push     = accept && (cmd != CMD_TICK);

  psdt_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .cmd             (cmd),
    .byte_value      (byte_value),
    .sending_enabled (sending_enabled),
    .pop             (pop),
    .accepted        (accepted),
    .nonempty        (nonempty),
    .queued_next     (queued_next),
    .head_byte       (head_byte),
    .pend_busy       (pend_busy)
  );

  psdt_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick),
    .nonempty    (nonempty),
    .phase_ticks (phase_ticks),
    .head_byte   (head_byte),
    .pop         (pop),
    .busy_next   (busy_next),
    .lines       (lines)
  );

  // Assemble the result from the state after this transaction.
  always_comb begin
    result.clock_low     = lines.clock_low;
    result.data_low      = lines.data_low;
    result.frame_busy    = busy_next;
    result.push_accepted = accepted;
    result.queued_bytes  = queued_next;
  end

  psdt_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .skid_full (skid_full)
  );

  assign clock_low     = out_data.clock_low;
  assign data_low      = out_data.data_low;
  assign frame_busy    = out_data.frame_busy;
  assign push_accepted = out_data.push_accepted;
  assign queued_bytes  = out_data.queued_bytes;

  // A byte only leaves the ring when one is there.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("ring pop while empty");

  // A pending break byte always comes from an accepted transaction.
  a_pend_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pend_busy) |-> $past(accept))
    else $error("pending write without accepted push");

  // No transaction is taken while the pending byte drains.
  a_pend_stall: assert property (@(posedge clk) disable iff (rst)
    pend_busy |-> !accept)
    else $error("transaction accepted during pending write");

  // A frame always ends with the lines released.
  a_end_release: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!lines.clock_low && !lines.data_low && !busy_next))
    else $error("lines driven at frame end");

endmodule
